// ===== rtl/mmcbd_pkg.sv =====
package mmcbd_pkg;

    localparam int PIX_W      = 32;
    localparam int COORD_W    = 9;
    localparam int LEVEL_W    = 4;
    localparam int PAIR_W     = 36;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // A finished level-one pixel waiting for the level cascade.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
    } item_t;

endpackage

// ===== rtl/mmcbd_ram.sv =====
module mmcbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 512
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mmcbd_fifo.sv =====
module mmcbd_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  mmcbd_pkg::item_t                   push_item,
    input  logic                               pop,
    output mmcbd_pkg::item_t                   head,
    output logic [mmcbd_pkg::FIFO_CNT_W-1:0]   count
);

    mmcbd_pkg::item_t                     mem_reg [mmcbd_pkg::FIFO_DEPTH];
    logic [mmcbd_pkg::FIFO_AW-1:0]        wr_ptr_reg;
    logic [mmcbd_pkg::FIFO_AW-1:0]        rd_ptr_reg;
    logic [mmcbd_pkg::FIFO_CNT_W-1:0]     count_reg;
    logic [mmcbd_pkg::FIFO_CNT_W-1:0]     count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== rtl/mipmap_chain_box_downsampler.sv =====
// Level-one results pass from the input register through the level-0 line buffer read, the
// cascade queue and the engine to the m_axis register; each further level of the same cascade
// waits on a read of the upper line buffer. Input beats are taken every cycle while the cascade
// queue has room; the output carries at most one result per cycle, and a deep cascade holds
// the queue. Reset (aresetn low, synchronous) clears all level counters and sets size_log2 to
// min(8, MAX_SIZE_LOG2); line buffers and held pixels are undefined but written before use.
module mipmap_chain_box_downsampler #(
    parameter int MAX_SIZE_LOG2 = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_level[3:0], out_x[12:4], out_y[21:13],
                                        // out_pixel[53:22], zero[55:54]
    output logic        m_axis_tlast    // last
);

    localparam int CW           = MAX_SIZE_LOG2;
    localparam int LW           = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int LIW          = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;
    localparam int L0_DEPTH     = 2 ** (MAX_SIZE_LOG2 - 1);
    localparam int L0_AW        = (L0_DEPTH > 1) ? $clog2(L0_DEPTH) : 1;
    localparam int UP_DEPTH     = (MAX_SIZE_LOG2 > 1) ? (2 ** (MAX_SIZE_LOG2 - 1) - 1) : 1;
    localparam int UP_AW        = (UP_DEPTH > 1) ? $clog2(UP_DEPTH) : 1;
    localparam int RESET_LEVELS = (MAX_SIZE_LOG2 < 8) ? MAX_SIZE_LOG2 : 8;
    localparam int RDY_W        = mmcbd_pkg::FIFO_CNT_W + 1;

    // Per-channel sums of two pixels, four 9-bit fields.
    function automatic logic [mmcbd_pkg::PAIR_W-1:0] pair_sum(
        input logic [mmcbd_pkg::PIX_W-1:0] a,
        input logic [mmcbd_pkg::PIX_W-1:0] b
    );
        logic [mmcbd_pkg::PAIR_W-1:0] r;
        for (int c = 0; c < 4; c++) begin
            r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
        end
        return r;
    endfunction

    // Adds two pair sums per channel and keeps sum / 4.
    function automatic logic [mmcbd_pkg::PIX_W-1:0] quad_mean(
        input logic [mmcbd_pkg::PAIR_W-1:0] top,
        input logic [mmcbd_pkg::PAIR_W-1:0] bot
    );
        logic [mmcbd_pkg::PIX_W-1:0] r;
        logic [9:0]                  s;
        for (int c = 0; c < 4; c++) begin
            s = {1'b0, top[9*c +: 9]} + {1'b0, bot[9*c +: 9]};
            r[8*c +: 8] = s[9:2];
        end
        return r;
    endfunction

    // Highest column index of a level whose side is 2^span.
    function automatic logic [CW-1:0] col_last(input logic [LW-1:0] span);
        logic [CW:0] w;
        w = (CW + 1)'(1) << span;
        return CW'(w - 1'b1);
    endfunction

    // Control state
    logic                  in_vld_reg;
    logic                  bv_reg;
    logic                  cur_vld_reg, cur_vld_next;
    logic                  cur_wait_reg, cur_wait_next;
    logic                  m_vld_reg;
    logic [LW-1:0]         levels_reg;
    logic [CW-1:0]         lc_reg [MAX_SIZE_LOG2];
    logic [CW-1:0]         lc_next [MAX_SIZE_LOG2];
    logic [CW-1:0]         lr_reg [MAX_SIZE_LOG2];
    logic [CW-1:0]         lr_next [MAX_SIZE_LOG2];

    // Payload
    logic [31:0]                        in_pix_reg;
    logic [mmcbd_pkg::PAIR_W-1:0]       pair_b_reg;
    logic [mmcbd_pkg::COORD_W-1:0]      bx_reg, by_reg;
    logic [mmcbd_pkg::PIX_W-1:0]        held_reg [MAX_SIZE_LOG2];
    logic [mmcbd_pkg::PIX_W-1:0]        held_next [MAX_SIZE_LOG2];
    logic [LW-1:0]                      cur_lvl_reg, cur_lvl_next;
    logic [mmcbd_pkg::COORD_W-1:0]      cur_x_reg, cur_x_next;
    logic [mmcbd_pkg::COORD_W-1:0]      cur_y_reg, cur_y_next;
    logic [mmcbd_pkg::PIX_W-1:0]        cur_pix_reg, cur_pix_next;
    logic [mmcbd_pkg::PAIR_W-1:0]       pair_e_reg, pair_e_next;
    logic [mmcbd_pkg::LEVEL_W-1:0]      m_level_reg;
    logic [mmcbd_pkg::COORD_W-1:0]      m_x_reg, m_y_reg;
    logic [mmcbd_pkg::PIX_W-1:0]        m_pix_reg;
    logic                               m_last_reg;

    // Base level
    logic                               fr_go;
    logic [CW-1:0]                      c0, r0, lim0;
    logic [mmcbd_pkg::PAIR_W-1:0]       fr_pair;
    logic                               ram0_we, ram0_re;
    logic [L0_AW-1:0]                   addr0;
    logic [mmcbd_pkg::PAIR_W-1:0]       ram0_rdata;

    // Cascade queue
    mmcbd_pkg::item_t                   push_item;
    mmcbd_pkg::item_t                   head;
    logic [mmcbd_pkg::FIFO_CNT_W-1:0]   fifo_count;
    logic                               pop;

    // Upper levels
    logic [LIW-1:0]                     lidx;
    logic [CW-1:0]                      ce, re_row, lim_e;
    logic                               out_free, emit, proc, eng_upd, cont;
    logic [mmcbd_pkg::PAIR_W-1:0]       eng_pair;
    logic [CW:0]                        up_half, up_part;
    logic [UP_AW-1:0]                   up_addr;
    logic                               ram1_we, ram1_re;
    logic [mmcbd_pkg::PAIR_W-1:0]       ram1_rdata;

    assign s_axis_tready = ({1'b0, fifo_count} + RDY_W'(in_vld_reg) + RDY_W'(bv_reg))
                           < RDY_W'(mmcbd_pkg::FIFO_DEPTH);

    // Level 0: pairs columns in the held pixel, then pairs rows through the line buffer.
    assign fr_go   = in_vld_reg && (levels_reg != '0);
    assign c0      = lc_reg[0];
    assign r0      = lr_reg[0];
    assign lim0    = col_last(levels_reg);
    assign fr_pair = pair_sum(held_reg[0], in_pix_reg);
    assign ram0_we = fr_go && c0[0] && !r0[0];
    assign ram0_re = fr_go && c0[0] && r0[0];
    assign addr0   = L0_AW'(c0 >> 1);

    mmcbd_ram #(
        .WIDTH (mmcbd_pkg::PAIR_W),
        .DEPTH (L0_DEPTH)
    ) u_ram_l0 (
        .aclk  (aclk),
        .we    (ram0_we),
        .waddr (addr0),
        .wdata (fr_pair),
        .re    (ram0_re),
        .raddr (addr0),
        .rdata (ram0_rdata)
    );

    assign push_item.x     = bx_reg;
    assign push_item.y     = by_reg;
    assign push_item.pixel = quad_mean(ram0_rdata, pair_b_reg);

    mmcbd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (bv_reg),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    // Cascade engine: emits the current pixel and feeds it to its own level's downsampler.
    assign lidx     = cur_lvl_reg[LIW-1:0];
    assign ce       = lc_reg[lidx];
    assign re_row   = lr_reg[lidx];
    assign lim_e    = col_last(levels_reg - cur_lvl_reg);
    assign out_free = !m_vld_reg || m_axis_tready;
    assign emit     = cur_vld_reg && !cur_wait_reg && out_free;
    assign proc     = cur_lvl_reg < levels_reg;
    assign eng_upd  = emit && proc;
    assign cont     = proc && ce[0] && re_row[0];
    assign eng_pair = pair_sum(held_reg[lidx], cur_pix_reg);
    assign pop      = (fifo_count != '0) && (!cur_vld_reg || (emit && !cont));

    // Level l owns entries from 2^(M-1) - 2^(M-l) up in the shared upper buffer.
    assign up_half  = (CW + 1)'(1) << (CW - 1);
    assign up_part  = (CW + 1)'(1) << (LW'(MAX_SIZE_LOG2) - cur_lvl_reg);
    assign up_addr  = UP_AW'(up_half - up_part + (CW + 1)'(ce >> 1));
    assign ram1_we  = eng_upd && ce[0] && !re_row[0];
    assign ram1_re  = emit && cont;

    mmcbd_ram #(
        .WIDTH (mmcbd_pkg::PAIR_W),
        .DEPTH (UP_DEPTH)
    ) u_ram_up (
        .aclk  (aclk),
        .we    (ram1_we),
        .waddr (up_addr),
        .wdata (eng_pair),
        .re    (ram1_re),
        .raddr (up_addr),
        .rdata (ram1_rdata)
    );

    always_comb begin
        lc_next   = lc_reg;
        lr_next   = lr_reg;
        held_next = held_reg;
        if (fr_go) begin
            if (c0 == lim0) begin
                lc_next[0] = '0;
                lr_next[0] = (r0 == lim0) ? '0 : r0 + 1'b1;
            end else begin
                lc_next[0] = c0 + 1'b1;
            end
            if (!c0[0]) begin
                held_next[0] = in_pix_reg;
            end
        end
        if (eng_upd) begin
            if (ce == lim_e) begin
                lc_next[lidx] = '0;
                lr_next[lidx] = (re_row == lim_e) ? '0 : re_row + 1'b1;
            end else begin
                lc_next[lidx] = ce + 1'b1;
            end
            if (!ce[0]) begin
                held_next[lidx] = cur_pix_reg;
            end
        end
        if (cfg_we) begin
            for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
                lc_next[i] = '0;
                lr_next[i] = '0;
            end
        end
    end

    always_comb begin
        cur_vld_next  = cur_vld_reg;
        cur_wait_next = cur_wait_reg;
        cur_lvl_next  = cur_lvl_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_pix_next  = cur_pix_reg;
        pair_e_next   = pair_e_reg;
        if (cur_wait_reg) begin
            cur_pix_next  = quad_mean(ram1_rdata, pair_e_reg);
            cur_wait_next = 1'b0;
        end else if (emit && cont) begin
            cur_wait_next = 1'b1;
            cur_lvl_next  = cur_lvl_reg + 1'b1;
            cur_x_next    = mmcbd_pkg::COORD_W'(ce >> 1);
            cur_y_next    = mmcbd_pkg::COORD_W'(re_row >> 1);
            pair_e_next   = eng_pair;
        end else if (pop) begin
            cur_vld_next  = 1'b1;
            cur_lvl_next  = LW'(1);
            cur_x_next    = head.x;
            cur_y_next    = head.y;
            cur_pix_next  = head.pixel;
        end else if (emit) begin
            cur_vld_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            bv_reg       <= 1'b0;
            cur_vld_reg  <= 1'b0;
            cur_wait_reg <= 1'b0;
            m_vld_reg    <= 1'b0;
            levels_reg   <= LW'(RESET_LEVELS);
            for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
                lc_reg[i] <= '0;
                lr_reg[i] <= '0;
            end
        end else begin
            in_vld_reg   <= s_axis_tvalid && s_axis_tready;
            bv_reg       <= ram0_re;
            cur_vld_reg  <= cur_vld_next;
            cur_wait_reg <= cur_wait_next;
            if (emit) begin
                m_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_vld_reg <= 1'b0;
            end
            if (cfg_we) begin
                levels_reg <= (cfg_wdata > 4'(MAX_SIZE_LOG2)) ? LW'(MAX_SIZE_LOG2)
                                                               : LW'(cfg_wdata);
            end
            lc_reg <= lc_next;
            lr_reg <= lr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_pix_reg <= s_axis_tdata;
        end
        if (ram0_re) begin
            pair_b_reg <= fr_pair;
            bx_reg     <= mmcbd_pkg::COORD_W'(c0 >> 1);
            by_reg     <= mmcbd_pkg::COORD_W'(r0 >> 1);
        end
        held_reg    <= held_next;
        cur_lvl_reg <= cur_lvl_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        cur_pix_reg <= cur_pix_next;
        pair_e_reg  <= pair_e_next;
        if (emit) begin
            m_level_reg <= mmcbd_pkg::LEVEL_W'(cur_lvl_reg);
            m_x_reg     <= cur_x_reg;
            m_y_reg     <= cur_y_reg;
            m_pix_reg   <= cur_pix_reg;
            m_last_reg  <= !cont;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {2'b00, m_pix_reg, m_y_reg, m_x_reg, m_level_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== bench/mipmap_chain_box_downsampler_test.sv =====
module mipmap_chain_box_downsampler_test;
    import mmcbd_pkg::*;

    localparam int MAX_LEVELS = 10;
    localparam int LINE_DEPTH = (1 << MAX_LEVELS) - 1;
    // Deepest cascade: the wait covers level one and every further level, with margin.
    localparam int SETTLE_CYCLES = 4 + 2 * MAX_LEVELS + 20;
    localparam int LONG_HOLD = 300;
    localparam int WIDE_PIXELS = 2 * 1024 + 2;
    localparam int RANDOM_PIXELS = 310;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pixel;
        logic               last;
    } mip_result_t;

    typedef enum logic {
        DO_PIXEL,
        DO_SIZE
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [31:0] value;
        logic        typed;
        logic [31:0] typed_pixel;
    } script_row_t;

    // A typed pixel is the single level-one result at (0,0) that closes a 2x2 image.
    script_row_t script [0:21] = '{
        '{DO_PIXEL, 32'h1234_5678, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h9abc_def0, 1'b0, 32'h0},
        '{DO_SIZE,  32'd1,         1'b0, 32'h0},
        '{DO_PIXEL, 32'hffff_ffff, 1'b0, 32'h0},
        '{DO_PIXEL, 32'hffff_ffff, 1'b0, 32'h0},
        '{DO_PIXEL, 32'hffff_ffff, 1'b0, 32'h0},
        '{DO_PIXEL, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
        '{DO_PIXEL, 32'h0000_0000, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0000_0000, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0000_0000, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{DO_PIXEL, 32'hffff_ffff, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0000_0000, 1'b0, 32'h0},
        '{DO_PIXEL, 32'hffff_ffff, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0000_0000, 1'b1, 32'h7f7f_7f7f},
        '{DO_PIXEL, 32'h0300_0103, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0300_0203, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0300_0303, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h0200_0302, 1'b1, 32'h0200_0202},
        '{DO_SIZE,  32'd0,         1'b0, 32'h0},
        '{DO_PIXEL, 32'ha5a5_a5a5, 1'b0, 32'h0},
        '{DO_PIXEL, 32'h5a5a_5a5a, 1'b0, 32'h0}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // pixel[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // out_level[3:0], out_x[12:4], out_y[21:13],
                                 // out_pixel[53:22], zero[55:54]
    logic        m_axis_tlast;   // last

    // Predictor state.
    logic [PAIR_W-1:0] top_pairs [LINE_DEPTH];
    logic [PIX_W-1:0]  held_left [MAX_LEVELS];
    int unsigned       level_col [MAX_LEVELS];
    int unsigned       level_row [MAX_LEVELS];
    logic [3:0]        size_code;

    mip_result_t step_mips[$];
    mip_result_t pending_mips[$];
    int          errors;
    int          beats_seen;
    bit          hold_request;

    mipmap_chain_box_downsampler #(
        .MAX_SIZE_LOG2(MAX_LEVELS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 aclk = ~aclk;

    function automatic logic [PAIR_W-1:0] pair_sums(input logic [31:0] a, input logic [31:0] b);
        logic [PAIR_W-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
        end
        return r;
    endfunction

    function automatic logic [31:0] box_mean(input logic [PAIR_W-1:0] top,
                                             input logic [PAIR_W-1:0] bottom);
        logic [31:0] r;
        logic [9:0]  s;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            s = {1'b0, top[9*c +: 9]} + {1'b0, bottom[9*c +: 9]};
            r[8*c +: 8] = s[9:2];
        end
        return r;
    endfunction

    // Runs one base pixel down the level cascade and leaves its results in step_mips.
    function automatic void cascade_pixel(input logic [31:0] px);
        int unsigned levels;
        int unsigned width;
        int unsigned col;
        int unsigned row;
        int unsigned nc;
        int unsigned idx;
        logic [31:0] cur;
        logic [31:0] avg;
        logic [PAIR_W-1:0] pair;
        mip_result_t r;
        step_mips.delete();
        levels = (size_code > MAX_LEVELS) ? MAX_LEVELS : size_code;
        cur = px;
        for (int unsigned l = 0; l < levels; l++) begin
            width = 1 << (levels - l);
            col = level_col[l];
            row = level_row[l];
            nc = col + 1;
            if (nc >= width) begin
                nc = 0;
                level_row[l] = (row + 1 >= width) ? 0 : row + 1;
            end
            level_col[l] = nc;
            if (col[0] == 1'b0) begin
                held_left[l] = cur;
                break;
            end
            pair = pair_sums(held_left[l], cur);
            idx = ((1 << MAX_LEVELS) - (1 << (MAX_LEVELS - l))) + (col >> 1);
            if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
            if (row[0] == 1'b0) begin
                top_pairs[idx] = pair;
                break;
            end
            avg = box_mean(top_pairs[idx], pair);
            r.level = LEVEL_W'(l + 1);
            r.x = COORD_W'(col >> 1);
            r.y = COORD_W'(row >> 1);
            r.pixel = avg;
            r.last = 1'b0;
            step_mips.push_back(r);
            cur = avg;
        end
        if (step_mips.size() > 0) begin
            r = step_mips.pop_back();
            r.last = 1'b1;
            step_mips.push_back(r);
        end
    endfunction

    function automatic logic [31:0] pick_pixel();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) return 32'hffff_ffff;
        else if (roll == 1) return 32'h0;
        else return $urandom();
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (errors < 40) begin
            $display("mismatch on %s at beat %0d: got %0h, expected %0h",
                     what, beats_seen, got, want);
        end
        errors++;
    endtask

    task automatic check_field(input string what, input longint unsigned got,
                               input longint unsigned want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    task automatic send_pixel(input logic [31:0] px, input logic typed,
                              input logic [31:0] typed_pixel);
        mip_result_t r;
        s_axis_tdata <= px;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        cascade_pixel(px);
        if (typed) begin
            r.level = LEVEL_W'(1);
            r.x = '0;
            r.y = '0;
            r.pixel = typed_pixel;
            r.last = 1'b1;
            pending_mips.push_back(r);
        end else begin
            foreach (step_mips[k]) pending_mips.push_back(step_mips[k]);
        end
    endtask

    task automatic idle_gap(input bit burst);
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60) n = 0;
        else if (roll < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 30);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_mips.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // The size register is written only with nothing in flight; a write restarts the image.
    task automatic load_size(input logic [3:0] code);
        s_axis_tvalid <= 1'b0;
        while (pending_mips.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wdata <= code;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        size_code = code;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            level_col[l] = 0;
            level_row[l] = 0;
        end
    endtask

    always @(posedge aclk) begin : result_check
        mip_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_mips.size() == 0) begin
                report_mismatch("beat with nothing expected", m_axis_tdata, 0);
            end else begin
                want = pending_mips.pop_front();
                check_field("out_level", m_axis_tdata[3:0], want.level);
                check_field("out_x", m_axis_tdata[12:4], want.x);
                check_field("out_y", m_axis_tdata[21:13], want.y);
                check_field("out_pixel", m_axis_tdata[53:22], want.pixel);
                check_field("padding", m_axis_tdata[55:54], 0);
                check_field("tlast", m_axis_tlast, want.last);
            end
            beats_seen++;
        end
    end

    initial begin : result_sink
        int on_len;
        int off_len;
        int roll;
        m_axis_tready = 1'b0;
        @(posedge aclk);
        forever begin
            // One long hold while results flow, so the cascade queue fills and input stalls.
            if (hold_request && m_axis_tvalid) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
            m_axis_tready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            roll = $urandom_range(0, 19);
            if (roll < 13) off_len = $urandom_range(1, 2);
            else if (roll < 19) off_len = $urandom_range(3, 6);
            else off_len = $urandom_range(10, 40);
            m_axis_tready <= 1'b0;
            repeat (off_len) @(posedge aclk);
        end
    end

    initial begin
        #20_000_000;
        $display("** mipmap_chain_box_downsampler: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int random_count;
        int roll;
        int pixels;
        bit burst;
        logic [3:0] code;
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        errors = 0;
        beats_seen = 0;
        hold_request = 1'b0;
        size_code = 4'd8;
        for (int l = 0; l < MAX_LEVELS; l++) begin
            level_col[l] = 0;
            level_row[l] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == DO_SIZE) begin
                load_size(script[i].value[3:0]);
            end else begin
                send_pixel(script[i].value, script[i].typed, script[i].typed_pixel);
                idle_gap(1'b0);
            end
        end

        // An oversized code saturates to the largest image; two full rows give every
        // level-one column. The two extra pixels start a row that the next write drops.
        load_size(4'd15);
        hold_request = 1'b1;
        for (int i = 0; i < WIDE_PIXELS; i++) begin
            send_pixel(pick_pixel(), 1'b0, 32'h0);
            if (i == 1600) pause_until_drained();
        end

        random_count = 0;
        while (random_count < RANDOM_PIXELS) begin
            roll = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            if (roll < 8) begin
                code = (roll < 4) ? 4'd0 : 4'($urandom_range(11, 15));
                pixels = $urandom_range(1, 12);
            end else if (roll < 20) begin
                code = 4'($urandom_range(1, 4));
                pixels = $urandom_range(1, (1 << (2 * code)) - 1);
            end else begin
                code = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 3)) : 4'd4;
                pixels = (1 << (2 * code)) * ((code == 4'd4) ? 1 : $urandom_range(1, 2));
            end
            load_size(code);
            repeat (pixels) begin
                send_pixel(pick_pixel(), 1'b0, 32'h0);
                random_count++;
                if ($urandom_range(0, 199) == 0) pause_until_drained();
                else idle_gap(burst);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_mips.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("** mipmap_chain_box_downsampler: PASSED **");
        end else begin
            $display("** mipmap_chain_box_downsampler: FAILED **");
        end
        $finish;
    end

endmodule
